/* rtl/core/rld_pkg.sv */
// ---------------------------------------------------------------------------
// rld_pkg: shared types and constants for the run list decoder
// Field sizes, header codes and the beat structures that pass between stages.
// ---------------------------------------------------------------------------
package rld_pkg;

    // Largest length or offset field size accepted, in bytes
    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

    // Header byte that terminates a list
    localparam logic [7:0] HDR_END = 8'h00;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_start;
    } t_in_beat;

    // One decoded run
    typedef struct packed {
        logic [63:0]        run_length;
        logic signed [63:0] cluster_delta;
        logic signed [63:0] start_cluster;
        logic               is_sparse;
        logic               list_end;
        logic               error_flag;
    } t_run;

endpackage

/* rtl/core/ntfs_run_list_decoder.sv */
// ---------------------------------------------------------------------------
// ntfs_run_list_decoder: NTFS data run list decoder, one byte per beat
// Parses header, length and offset fields and emits absolute runs.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one run list byte per beat;
//   i_list_start marks the first byte of a list and clears the cluster base.
//   Output channel (o_valid / i_ready) carries one decoded run per beat:
//   length, signed delta, absolute start cluster and sparse / end / error
//   flags. Non-final field bytes give no output beat, nor do headers other
//   than a terminator or an oversized one. Throughput: one byte per cycle
//   while the receiver keeps up. The last field byte of a run sits in the
//   input register while decode and the 64-bit base add run, then the run
//   lands in the result register and shows on o_valid.
//   Reset clears the parser, the cluster base and both stage valids; the
//   first list may start with or without i_list_start.
//   When the receiver stalls, bytes that give no run still move through;
//   a byte that would give a run waits in the input register, and o_ready
//   falls once that register is full and the result still waits.
//   After a terminator or an oversized field, bytes are dropped until the
//   next i_list_start.
// ---------------------------------------------------------------------------
module ntfs_run_list_decoder
    import rld_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_list_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_run_length,
    output logic signed [63:0] o_cluster_delta,
    output logic signed [63:0] o_start_cluster,
    output logic               o_is_sparse,
    output logic               o_list_end,
    output logic               o_error_flag
);

    t_in_beat in_beat;
    t_in_beat held_beat;
    logic     held_valid;
    logic     step;
    logic     has_run;
    t_run     run;
    t_run     out_run;

    assign in_beat.data_byte  = i_data_byte;
    assign in_beat.list_start = i_list_start;

    // Step when the result slot is free or this byte gives no run
    assign step = held_valid && (!o_valid || i_ready || !has_run);

    rld_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_beat  (in_beat),
        .i_step  (step),
        .o_valid (held_valid),
        .o_beat  (held_beat)
    );

    rld_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_beat    (held_beat),
        .o_has_run (has_run),
        .o_run     (run)
    );

    rld_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && has_run),
        .i_run   (run),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_run   (out_run)
    );

    assign o_run_length    = out_run.run_length;
    assign o_cluster_delta = out_run.cluster_delta;
    assign o_start_cluster = out_run.start_cluster;
    assign o_is_sparse     = out_run.is_sparse;
    assign o_list_end      = out_run.list_end;
    assign o_error_flag    = out_run.error_flag;

endmodule

/* rtl/core/rld_in_reg.sv */
// ---------------------------------------------------------------------------
// rld_in_reg: input register stage
// Captures one byte beat; releases it when the parser steps.
// ---------------------------------------------------------------------------
module rld_in_reg
    import rld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_beat,
    input  logic     i_step,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // Free when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

/* rtl/core/rld_parser.sv */
// ---------------------------------------------------------------------------
// rld_parser: run list parse state and per-byte decode
// Header, length and offset phases; accumulates fields and the cluster base.
// ---------------------------------------------------------------------------
module rld_parser
    import rld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_beat i_beat,
    output logic     o_has_run,
    output t_run     o_run
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_HALTED = 2'd3
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [3:0]  r_off_left, n_off_left;
    logic [3:0]  r_osize,    n_osize;
    logic [2:0]  r_pos,      n_pos;
    logic [63:0] r_len_acc,  n_len_acc;
    logic [63:0] r_off_acc,  n_off_acc;
    logic [63:0] r_base,     n_base;

    t_phase      cur_phase;
    logic [63:0] base_in;
    logic [63:0] byte_shifted;
    logic [3:0]  lsz;
    logic [3:0]  osz;
    logic [63:0] off_full;
    logic [63:0] delta;
    logic [63:0] ext_mask;
    logic [5:0]  sign_idx;
    logic [3:0]  left_dec;

    // A list start clears the parser and base ahead of this byte
    assign cur_phase = i_beat.list_start ? PH_HEADER : r_phase;
    assign base_in   = i_beat.list_start ? 64'd0 : r_base;

    assign lsz          = i_beat.data_byte[3:0];
    assign osz          = i_beat.data_byte[7:4];
    assign byte_shifted = {56'd0, i_beat.data_byte} << {r_pos, 3'b000};

    // Sign extension of a short offset field
    assign off_full = r_off_acc | byte_shifted;
    assign sign_idx = {r_osize[2:0], 3'b000} - 6'd1;
    assign ext_mask = ~64'd0 << {r_osize[2:0], 3'b000};
    always_comb begin
        delta = off_full;
        if (r_osize != 4'd0 && r_osize < 4'd8 && off_full[sign_idx]) begin
            delta = off_full | ext_mask;
        end
    end

    // Next state and result for the byte in hand
    always_comb begin
        n_phase    = cur_phase;
        n_len_left = r_len_left;
        n_off_left = r_off_left;
        n_osize    = r_osize;
        n_pos      = r_pos;
        n_len_acc  = r_len_acc;
        n_off_acc  = r_off_acc;
        n_base     = base_in;
        o_has_run  = 1'b0;
        o_run      = '0;
        left_dec   = 4'd0;

        case (cur_phase)
            PH_HEADER: begin
                n_pos     = 3'd0;
                n_len_acc = 64'd0;
                n_off_acc = 64'd0;
                if (i_beat.data_byte == HDR_END) begin
                    n_phase        = PH_HALTED;
                    n_len_left     = 4'd0;
                    n_off_left     = 4'd0;
                    n_osize        = 4'd0;
                    o_has_run      = 1'b1;
                    o_run.list_end = 1'b1;
                end else if (lsz > MAX_FIELD_BYTES || osz > MAX_FIELD_BYTES) begin
                    n_phase          = PH_HALTED;
                    n_len_left       = 4'd0;
                    n_off_left       = 4'd0;
                    n_osize          = 4'd0;
                    o_has_run        = 1'b1;
                    o_run.error_flag = 1'b1;
                end else begin
                    n_len_left = lsz;
                    n_off_left = osz;
                    n_osize    = osz;
                    n_phase    = (lsz != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                n_len_acc  = r_len_acc | byte_shifted;
                n_pos      = r_pos + 3'd1;
                left_dec   = (r_len_left != 4'd0) ? r_len_left - 4'd1 : 4'd0;
                n_len_left = left_dec;
                if (left_dec == 4'd0) begin
                    n_pos = 3'd0;
                    if (r_off_left == 4'd0) begin
                        // Sparse run: no offset field
                        o_has_run        = 1'b1;
                        o_run.run_length = n_len_acc;
                        o_run.is_sparse  = 1'b1;
                        n_phase          = PH_HEADER;
                        n_len_acc        = 64'd0;
                        n_off_acc        = 64'd0;
                        n_osize          = 4'd0;
                    end else begin
                        n_phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc  = off_full;
                n_pos      = r_pos + 3'd1;
                left_dec   = (r_off_left != 4'd0) ? r_off_left - 4'd1 : 4'd0;
                n_off_left = left_dec;
                if (left_dec == 4'd0) begin
                    n_base              = base_in + delta;
                    o_has_run           = 1'b1;
                    o_run.run_length    = r_len_acc;
                    o_run.cluster_delta = delta;
                    o_run.start_cluster = n_base;
                    n_phase             = PH_HEADER;
                    n_len_left          = 4'd0;
                    n_pos               = 3'd0;
                    n_len_acc           = 64'd0;
                    n_off_acc           = 64'd0;
                    n_osize             = 4'd0;
                end
            end
            PH_HALTED: begin
                // Bytes ignored until the next list start
            end
            default: begin
                n_phase = PH_HALTED;
            end
        endcase
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_len_left <= 4'd0;
            r_off_left <= 4'd0;
            r_osize    <= 4'd0;
            r_pos      <= 3'd0;
            r_len_acc  <= 64'd0;
            r_off_acc  <= 64'd0;
            r_base     <= 64'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_osize    <= n_osize;
            r_pos      <= n_pos;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_base     <= n_base;
        end
    end

endmodule

/* rtl/core/rld_out_reg.sv */
// ---------------------------------------------------------------------------
// rld_out_reg: result register
// Holds one decoded run until the receiver takes the beat.
// ---------------------------------------------------------------------------
module rld_out_reg
    import rld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_run i_run,
    input  logic i_ready,
    output logic o_valid,
    output t_run o_run
);

    logic r_valid;
    t_run r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

    assign o_valid = r_valid;
    assign o_run   = r_run;

endmodule

/* rtl/core/rld_checker.sv */
// ---------------------------------------------------------------------------
// rld_checker: port-level checks for the run list decoder
// Output beat stability, reset behaviour and consistency of run flags.
// ---------------------------------------------------------------------------
module rld_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [63:0]        o_run_length,
    input logic signed [63:0] o_cluster_delta,
    input logic signed [63:0] o_start_cluster,
    input logic               o_is_sparse,
    input logic               o_list_end,
    input logic               o_error_flag
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_run_length)
            && $stable(o_start_cluster) && $stable(o_cluster_delta))
        else $error("output beat changed while stalled");

    // Output stage empty and input open after reset
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("stage not cleared by reset");

    // Terminator and error beats carry no run
    a_end_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_list_end || o_error_flag) |->
            o_run_length == 64'd0 && o_start_cluster == 64'sd0 && !o_is_sparse
            && !(o_list_end && o_error_flag))
        else $error("terminator or error beat carries run data");

    // Sparse runs carry no cluster position
    a_sparse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_sparse |->
            o_cluster_delta == 64'sd0 && o_start_cluster == 64'sd0)
        else $error("sparse run with a cluster position");

    // Input stays open while the output is empty
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !$past(i_valid) |-> o_ready)
        else $error("input blocked with an empty output");

endmodule

bind ntfs_run_list_decoder rld_checker u_rld_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_run_length    (o_run_length),
    .o_cluster_delta (o_cluster_delta),
    .o_start_cluster (o_start_cluster),
    .o_is_sparse     (o_is_sparse),
    .o_list_end      (o_list_end),
    .o_error_flag    (o_error_flag)
);
